FILE: src/ilt_pkg.sv
// shared types and constants for the identifier list table
package ilt_pkg;

  localparam int CAPACITY   = 16;
  localparam int IDENT_BITS = 32;

  localparam int ADDR_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);
  localparam int POS_BITS   = 4;
  localparam int FIDX_BITS  = 4;
  localparam int OID_BITS   = 32;
  localparam int ECNT_BITS  = 5;
  localparam int WIDE_BITS  = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_READ
  } state_t;

  typedef struct packed {
    action_t               action;
    logic [OID_BITS-1:0]   ident;
    logic [POS_BITS-1:0]   position;
  } in_item_t;

  typedef struct packed {
    logic                  status;
    logic                  found;
    logic [FIDX_BITS-1:0]  found_index;
    logic [OID_BITS-1:0]   read_ident;
    logic [ECNT_BITS-1:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic                  we;
    logic [ADDR_BITS-1:0]  waddr;
    logic [IDENT_BITS-1:0] wdata;
    logic [ADDR_BITS-1:0]  raddr;
  } mem_req_t;

endpackage

FILE: src/ilt_ram.sv
// entry store: one write port, one registered read port
module ilt_ram (
  input  logic                           clk,
  input  ilt_pkg::mem_req_t              req,
  output logic [ilt_pkg::IDENT_BITS-1:0] rdata
);

  logic [ilt_pkg::IDENT_BITS-1:0] mem [ilt_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

FILE: src/ilt_ctrl.sv
// request sequencer: count, scan, shift and result register
module ilt_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  ilt_pkg::in_item_t              in_item,
  output logic                           out_valid,
  output ilt_pkg::out_item_t             out_item,
  output ilt_pkg::mem_req_t              mem_req,
  input  logic [ilt_pkg::IDENT_BITS-1:0] mem_rdata
);

  ilt_pkg::state_t                 state_r, state_nxt;
  logic [ilt_pkg::CNT_BITS-1:0]    count_r, count_nxt;
  logic [ilt_pkg::ADDR_BITS-1:0]   idx_r, idx_nxt;
  ilt_pkg::action_t                act_r, act_nxt;
  logic [ilt_pkg::IDENT_BITS-1:0]  ident_r, ident_nxt;
  logic                            out_valid_r, out_valid_nxt;
  ilt_pkg::out_item_t              out_item_r, res;

  logic [ilt_pkg::IDENT_BITS-1:0]  in_ident;
  logic [ilt_pkg::CNT_BITS-1:0]    idx_p1, idx_p2;
  logic                            full, empty, match, more1, more2, pos_bad;

  assign in_ident = ilt_pkg::IDENT_BITS'(in_item.ident);
  assign idx_p1   = ilt_pkg::CNT_BITS'(idx_r) + ilt_pkg::CNT_BITS'(1);
  assign idx_p2   = ilt_pkg::CNT_BITS'(idx_r) + ilt_pkg::CNT_BITS'(2);
  assign full     = (count_r == ilt_pkg::CNT_BITS'(ilt_pkg::CAPACITY));
  assign empty    = (count_r == '0);
  assign match    = (mem_rdata == ident_r);
  assign more1    = (idx_p1 < count_r);
  assign more2    = (idx_p2 < count_r);
  assign pos_bad  = (ilt_pkg::WIDE_BITS'(in_item.position) >=
                     ilt_pkg::WIDE_BITS'(count_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ilt_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    act_r   <= act_nxt;
    ident_r <= ident_nxt;
    if (out_valid_nxt) begin
      out_item_r <= res;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    act_nxt       = act_r;
    ident_nxt     = ident_r;
    out_valid_nxt = 1'b0;
    res           = '0;
    mem_req.we    = 1'b0;
    mem_req.waddr = idx_r;
    mem_req.wdata = mem_rdata;
    mem_req.raddr = idx_r;

    unique case (state_r)
      ilt_pkg::ST_IDLE: begin
        if (start) begin
          act_nxt   = in_item.action;
          ident_nxt = in_ident;
          idx_nxt   = '0;
          unique case (in_item.action)
            ilt_pkg::ACT_ADD: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                res.status = 1'b1;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ilt_pkg::ADDR_BITS'(count_r);
                mem_req.wdata = in_ident;
                count_nxt     = count_r + ilt_pkg::CNT_BITS'(1);
              end
            end
            ilt_pkg::ACT_DELETE, ilt_pkg::ACT_FIND: begin
              mem_req.raddr = '0;
              if (empty) begin
                out_valid_nxt = 1'b1;
                res.status    = (in_item.action == ilt_pkg::ACT_DELETE);
              end else begin
                state_nxt = ilt_pkg::ST_SCAN;
              end
            end
            ilt_pkg::ACT_READ: begin
              mem_req.raddr = ilt_pkg::ADDR_BITS'(in_item.position);
              if (pos_bad) begin
                out_valid_nxt = 1'b1;
                res.status    = 1'b1;
              end else begin
                state_nxt = ilt_pkg::ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ilt_pkg::ST_SCAN: begin
        if (match) begin
          if (act_r == ilt_pkg::ACT_FIND) begin
            out_valid_nxt     = 1'b1;
            res.found         = 1'b1;
            res.found_index   = ilt_pkg::FIDX_BITS'(idx_r);
            state_nxt         = ilt_pkg::ST_IDLE;
          end else if (more1) begin
            mem_req.raddr = ilt_pkg::ADDR_BITS'(idx_p1);
            state_nxt     = ilt_pkg::ST_SHIFT;
          end else begin
            count_nxt     = count_r - ilt_pkg::CNT_BITS'(1);
            out_valid_nxt = 1'b1;
            state_nxt     = ilt_pkg::ST_IDLE;
          end
        end else if (more1) begin
          idx_nxt       = ilt_pkg::ADDR_BITS'(idx_p1);
          mem_req.raddr = ilt_pkg::ADDR_BITS'(idx_p1);
        end else begin
          out_valid_nxt = 1'b1;
          res.status    = (act_r == ilt_pkg::ACT_DELETE);
          state_nxt     = ilt_pkg::ST_IDLE;
        end
      end
      ilt_pkg::ST_SHIFT: begin
        // rdata holds entry idx+1, move it down to idx
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = mem_rdata;
        if (more2) begin
          idx_nxt       = ilt_pkg::ADDR_BITS'(idx_p1);
          mem_req.raddr = ilt_pkg::ADDR_BITS'(idx_p2);
        end else begin
          count_nxt     = count_r - ilt_pkg::CNT_BITS'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = ilt_pkg::ST_IDLE;
        end
      end
      ilt_pkg::ST_READ: begin
        out_valid_nxt  = 1'b1;
        res.read_ident = ilt_pkg::OID_BITS'(mem_rdata);
        state_nxt      = ilt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ilt_pkg::ST_IDLE;
      end
    endcase

    res.entry_count = ilt_pkg::ECNT_BITS'(count_nxt);
  end

  assign busy      = (state_r != ilt_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: src/id_list_table.sv
// top level of the identifier list table
// A request is taken when start is high and busy is low; its one result beat
// appears on out_item with out_valid high for a single cycle and cannot be
// held off, so the receiver must take it then. Busy stays high until the cycle
// before the result beat, so one request is in flight at a time. The entries
// live in a single-port-read memory, which sets the timing: add, and any
// request that fails at once, gives its result in the cycle after acceptance;
// read passes through the memory read register and the read state; find and
// delete walk the list one entry per cycle through the memory read port, and
// delete then moves each later entry down at one entry per cycle. The entries
// need no clearing after reset.
module id_list_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ilt_pkg::in_item_t   in_item,
  output logic                out_valid,
  output ilt_pkg::out_item_t  out_item
);

  ilt_pkg::mem_req_t              mem_req;
  logic [ilt_pkg::IDENT_BITS-1:0] mem_rdata;

  ilt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  ilt_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule
